// ===== rtl/sem_pkg.sv =====
`timescale 1ns / 1ps

package sem_pkg;

    // Fixed field widths
    localparam int PIXEL_BITS     = 8;
    localparam int CFG_BITS       = 11;
    localparam int CFG_INDEX_BITS = 1;
    localparam int ROW_BITS       = 10;
    localparam int COORD_BITS     = 10;

    // Frame limits
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int HEIGHT_LIMIT  = 1024;
    localparam int MIN_DIM       = 3;
    localparam int FIRST_INNER   = 2;
    localparam int EDGE_MAX      = 255;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef logic [PIXEL_BITS-1:0] t_pixel;

    // One interior window, ready for the gradient arithmetic.
    // l*, m*, r* are the left, middle and right columns; t/m/b the rows.
    typedef struct packed {
        t_pixel                lt;
        t_pixel                lm;
        t_pixel                lb;
        t_pixel                mt;
        t_pixel                mb;
        t_pixel                rt;
        t_pixel                rm;
        t_pixel                rb;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic                  last;
    } t_sem_job;

endpackage

// ===== rtl/sobel_edge_magnitude_stream_top.sv =====
`timescale 1ns / 1ps

// Streaming 3x3 Sobel edge detector, L1 magnitude clamped to 255.
// Input channel: one grey pixel per transfer in raster order (i_valid,
// o_stall, i_pixel_in, i_frame_start). Raise i_frame_start on the first
// pixel of a frame to restart the row and column count at (0,0).
// Output channel: one transfer per interior pixel (o_valid, i_stall,
// o_edge_value, o_centre_row, o_centre_col, o_frame_last). Border pixels
// give no transfer; o_frame_last marks the last interior pixel of a frame.
// Frame size comes from the write port (index 0 width, index 1 height),
// clamped to 3..MAX_WIDTH and 3..1024; write only while the block is idle.
// Throughput: one pixel per clock while o_stall is low. Once the pixel that
// completes a window is taken, its result passes through the front's second
// stage register, the queue, the gradient register and the output register.
// When the receiver stalls, the output register holds and a four-entry
// queue absorbs work in flight; o_stall rises only once that queue is full.
// Reset clears the counters, window and handshake state and sets both frame
// registers to 1024; the line store is not cleared and needs no sweep.
module sobel_edge_magnitude_stream_top #(
    parameter int MAX_WIDTH = sem_pkg::DEF_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [sem_pkg::PIXEL_BITS-1:0]      i_pixel_in,
    input  logic                                i_frame_start,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [sem_pkg::PIXEL_BITS-1:0]      o_edge_value,
    output logic [sem_pkg::COORD_BITS-1:0]      o_centre_row,
    output logic [sem_pkg::COORD_BITS-1:0]      o_centre_col,
    output logic                                o_frame_last,
    input  logic                                i_cfg_we,
    input  logic [sem_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [sem_pkg::CFG_BITS-1:0]        i_cfg_data
);

    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              take;
    sem_pkg::t_sem_job front_job;
    sem_pkg::t_sem_job back_job;

    // Front: counters, line store and window; forward interior windows only
    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_pixel_in    (i_pixel_in),
        .i_frame_start (i_frame_start),
        .o_stall       (o_stall),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push        (push),
        .o_job         (front_job),
        .i_full        (q_full)
    );

    // Decouple the two halves so a receiver stall does not stop the front at once
    sem_queue #(
        .DEPTH (sem_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (take),
        .o_job   (back_job),
        .o_valid (q_valid)
    );

    // Back: gradients, magnitude and the output register
    sem_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job        (back_job),
        .o_job_take   (take),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_edge_value (o_edge_value),
        .o_centre_row (o_centre_row),
        .o_centre_col (o_centre_col),
        .o_frame_last (o_frame_last)
    );

endmodule

// ===== rtl/sem_front.sv =====
`timescale 1ns / 1ps

module sem_front #(
    parameter int MAX_WIDTH = sem_pkg::DEF_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [sem_pkg::PIXEL_BITS-1:0]      i_pixel_in,
    input  logic                                i_frame_start,
    output logic                                o_stall,
    input  logic                                i_cfg_we,
    input  logic [sem_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [sem_pkg::CFG_BITS-1:0]        i_cfg_data,
    output logic                                o_push,
    output sem_pkg::t_sem_job                   o_job,
    input  logic                                i_full
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int CMP_BITS = (W_BITS > sem_pkg::CFG_BITS) ? W_BITS : sem_pkg::CFG_BITS;
    localparam int EXT_BITS = (COL_BITS > sem_pkg::COORD_BITS) ? COL_BITS
                                                                : sem_pkg::COORD_BITS;
    localparam int H_BITS   = sem_pkg::CFG_BITS;
    localparam int R_BITS   = sem_pkg::ROW_BITS;
    localparam int LINE_BITS = 2 * sem_pkg::PIXEL_BITS;

    // Configuration
    logic [sem_pkg::CFG_BITS-1:0] r_frame_width;
    logic [sem_pkg::CFG_BITS-1:0] r_frame_height;

    // Counters
    logic [R_BITS-1:0]   r_row;
    logic [COL_BITS-1:0] r_col;
    logic [R_BITS-1:0]   n_row;
    logic [COL_BITS-1:0] n_col;

    // Line store: {older, newer} per column
    logic [LINE_BITS-1:0] r_line_mem [MAX_WIDTH];
    logic [LINE_BITS-1:0] r_line_q;

    // Second stage
    logic                             r_s1_valid;
    logic                             r_s1_prod;
    logic [COL_BITS-1:0]              r_s1_col;
    sem_pkg::t_pixel                  r_s1_pix;
    logic [sem_pkg::COORD_BITS-1:0]   r_s1_row_m1;
    logic [sem_pkg::COORD_BITS-1:0]   r_s1_col_m1;
    logic                             r_s1_last;

    // Window: 0..2 left column, 3..5 middle column (top, mid, bottom)
    sem_pkg::t_pixel r_win [6];

    logic [CMP_BITS-1:0] w_ext;
    logic [CMP_BITS-1:0] w_cmp;
    logic [W_BITS-1:0]   w_eff;
    logic [H_BITS-1:0]   h_eff;

    logic [R_BITS-1:0]   row_a;
    logic [COL_BITS-1:0] col_a;
    logic                col_wrap;
    logic [H_BITS-1:0]   row_b;
    logic [R_BITS-1:0]   cur_row;
    logic [COL_BITS-1:0] cur_col;
    logic [W_BITS-1:0]   col_inc;
    logic [H_BITS-1:0]   row_inc;
    logic                end_row;
    logic                end_frame;
    logic                cur_prod;
    logic                cur_last;
    logic [R_BITS-1:0]   cur_row_m1;
    logic [COL_BITS-1:0] cur_col_m1;
    logic [EXT_BITS-1:0] col_m1_ext;

    logic                 acc;
    logic                 s1_adv;
    logic                 fwd;
    sem_pkg::t_pixel      top;
    sem_pkg::t_pixel      mid;
    logic [LINE_BITS-1:0] wr_data;

    // Clamp the registers into their legal ranges
    always_comb begin
        w_ext = CMP_BITS'(r_frame_width);
        if (w_ext < CMP_BITS'(sem_pkg::MIN_DIM)) begin
            w_cmp = CMP_BITS'(sem_pkg::MIN_DIM);
        end else if (w_ext > CMP_BITS'(MAX_WIDTH)) begin
            w_cmp = CMP_BITS'(MAX_WIDTH);
        end else begin
            w_cmp = w_ext;
        end
        w_eff = w_cmp[W_BITS-1:0];

        if (r_frame_height < H_BITS'(sem_pkg::MIN_DIM)) begin
            h_eff = H_BITS'(sem_pkg::MIN_DIM);
        end else if (r_frame_height > H_BITS'(sem_pkg::HEIGHT_LIMIT)) begin
            h_eff = H_BITS'(sem_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = r_frame_height;
        end
    end

    // Position of the incoming pixel and the counters after it
    always_comb begin
        row_a    = i_frame_start ? '0 : r_row;
        col_a    = i_frame_start ? '0 : r_col;
        col_wrap = W_BITS'(col_a) >= w_eff;
        row_b    = col_wrap ? H_BITS'(row_a) + H_BITS'(1) : H_BITS'(row_a);
        cur_col  = col_wrap ? '0 : col_a;
        cur_row  = (row_b >= h_eff) ? '0 : row_b[R_BITS-1:0];

        col_inc   = W_BITS'(cur_col) + W_BITS'(1);
        row_inc   = H_BITS'(cur_row) + H_BITS'(1);
        end_row   = col_inc == w_eff;
        end_frame = row_inc >= h_eff;

        if (end_row) begin
            n_col = '0;
            n_row = end_frame ? '0 : row_inc[R_BITS-1:0];
        end else begin
            n_col = col_inc[COL_BITS-1:0];
            n_row = cur_row;
        end

        cur_prod   = (cur_row >= R_BITS'(sem_pkg::FIRST_INNER))
                  && (W_BITS'(cur_col) >= W_BITS'(sem_pkg::FIRST_INNER));
        cur_last   = end_row && end_frame;
        cur_row_m1 = cur_row - R_BITS'(1);
        cur_col_m1 = cur_col - COL_BITS'(1);
        col_m1_ext = EXT_BITS'(cur_col_m1);
    end

    assign o_stall = r_s1_valid && r_s1_prod && i_full;
    assign s1_adv  = !o_stall;
    assign acc     = i_valid && !o_stall;

    assign top     = r_line_q[LINE_BITS-1:sem_pkg::PIXEL_BITS];
    assign mid     = r_line_q[sem_pkg::PIXEL_BITS-1:0];
    assign wr_data = {mid, r_s1_pix};
    // A column written back this cycle is read again only after a frame restart
    assign fwd     = r_s1_valid && (r_s1_col == cur_col);

    assign o_push = r_s1_valid && r_s1_prod && s1_adv;

    always_comb begin
        o_job.lt   = r_win[0];
        o_job.lm   = r_win[1];
        o_job.lb   = r_win[2];
        o_job.mt   = r_win[3];
        o_job.mb   = r_win[5];
        o_job.rt   = top;
        o_job.rm   = mid;
        o_job.rb   = r_s1_pix;
        o_job.row  = r_s1_row_m1;
        o_job.col  = r_s1_col_m1;
        o_job.last = r_s1_last;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= sem_pkg::CFG_BITS'(sem_pkg::DEF_MAX_WIDTH);
            r_frame_height <= sem_pkg::CFG_BITS'(sem_pkg::HEIGHT_LIMIT);
            r_row          <= '0;
            r_col          <= '0;
            r_s1_valid     <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sem_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    sem_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (acc) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (s1_adv) begin
                r_s1_valid <= acc;
            end
            if (r_s1_valid && s1_adv) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top;
                r_win[4] <= mid;
                r_win[5] <= r_s1_pix;
            end
        end
    end

    // Payload of the second stage
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_prod   <= cur_prod;
            r_s1_col    <= cur_col;
            r_s1_pix    <= i_pixel_in;
            r_s1_row_m1 <= cur_row_m1;
            r_s1_col_m1 <= col_m1_ext[sem_pkg::COORD_BITS-1:0];
            r_s1_last   <= cur_last;
        end
    end

    // Line store: read at the new column, write back the shifted pair
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_line_mem[r_s1_col] <= wr_data;
        end
        if (acc) begin
            r_line_q <= fwd ? wr_data : r_line_mem[cur_col];
        end
    end

endmodule

// ===== rtl/sem_queue.sv =====
`timescale 1ns / 1ps

module sem_queue #(
    parameter int DEPTH = sem_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sem_pkg::t_sem_job i_job,
    output logic              o_full,
    input  logic              i_pop,
    output sem_pkg::t_sem_job o_job,
    output logic              o_valid
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    sem_pkg::t_sem_job   r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = r_count == CNT_BITS'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : r_wr_ptr + PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : r_rd_ptr + PTR_BITS'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/sem_back.sv =====
`timescale 1ns / 1ps

module sem_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_job_valid,
    input  sem_pkg::t_sem_job                   i_job,
    output logic                                o_job_take,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [sem_pkg::PIXEL_BITS-1:0]      o_edge_value,
    output logic [sem_pkg::COORD_BITS-1:0]      o_centre_row,
    output logic [sem_pkg::COORD_BITS-1:0]      o_centre_col,
    output logic                                o_frame_last
);

    localparam int SUM_BITS  = sem_pkg::PIXEL_BITS + 2;
    localparam int GRAD_BITS = SUM_BITS + 1;
    localparam int MAG_BITS  = SUM_BITS + 1;

    logic                           r_b1_valid;
    logic signed [GRAD_BITS-1:0]    r_gx;
    logic signed [GRAD_BITS-1:0]    r_gy;
    logic [sem_pkg::COORD_BITS-1:0] r_b1_row;
    logic [sem_pkg::COORD_BITS-1:0] r_b1_col;
    logic                           r_b1_last;

    logic [SUM_BITS-1:0]         sum_l;
    logic [SUM_BITS-1:0]         sum_r;
    logic [SUM_BITS-1:0]         sum_t;
    logic [SUM_BITS-1:0]         sum_b;
    logic signed [GRAD_BITS-1:0] gx;
    logic signed [GRAD_BITS-1:0] gy;
    logic [SUM_BITS-1:0]         abs_x;
    logic [SUM_BITS-1:0]         abs_y;
    logic [MAG_BITS-1:0]         mag;
    logic [sem_pkg::PIXEL_BITS-1:0] edge_val;

    logic out_adv;
    logic b1_adv;

    assign out_adv    = !o_valid || !i_stall;
    assign b1_adv     = !r_b1_valid || out_adv;
    assign o_job_take = i_job_valid && b1_adv;

    // Weighted column and row sums, then the two gradients
    always_comb begin
        sum_l = SUM_BITS'(i_job.lt) + {1'b0, i_job.lm, 1'b0} + SUM_BITS'(i_job.lb);
        sum_r = SUM_BITS'(i_job.rt) + {1'b0, i_job.rm, 1'b0} + SUM_BITS'(i_job.rb);
        sum_t = SUM_BITS'(i_job.lt) + {1'b0, i_job.mt, 1'b0} + SUM_BITS'(i_job.rt);
        sum_b = SUM_BITS'(i_job.lb) + {1'b0, i_job.mb, 1'b0} + SUM_BITS'(i_job.rb);
        gx    = $signed({1'b0, sum_l}) - $signed({1'b0, sum_r});
        gy    = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
    end

    // L1 magnitude, clamped to the pixel range
    always_comb begin
        abs_x = r_gx[GRAD_BITS-1] ? SUM_BITS'(-r_gx) : SUM_BITS'(r_gx);
        abs_y = r_gy[GRAD_BITS-1] ? SUM_BITS'(-r_gy) : SUM_BITS'(r_gy);
        mag   = MAG_BITS'(abs_x) + MAG_BITS'(abs_y);
        if (mag > MAG_BITS'(sem_pkg::EDGE_MAX)) begin
            edge_val = sem_pkg::PIXEL_BITS'(sem_pkg::EDGE_MAX);
        end else begin
            edge_val = mag[sem_pkg::PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            if (b1_adv) begin
                r_b1_valid <= i_job_valid;
            end
            if (out_adv) begin
                o_valid <= r_b1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_gx      <= gx;
            r_gy      <= gy;
            r_b1_row  <= i_job.row;
            r_b1_col  <= i_job.col;
            r_b1_last <= i_job.last;
        end
        if (out_adv && r_b1_valid) begin
            o_edge_value <= edge_val;
            o_centre_row <= r_b1_row;
            o_centre_col <= r_b1_col;
            o_frame_last <= r_b1_last;
        end
    end

endmodule
